### sv/assert_macros.svh
// Assertion macros used by the checker file dmc_checker.sv.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet during reset.
`define DMC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, quiet during reset.
`define DMC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/dmc_pkg.sv
// Constants, types and helper functions of the maze carver.
// No dependencies; used by dfs_maze_carver and dmc_checker.
package dmc_pkg;

    localparam int MAX_COLS      = 64;
    localparam int MAX_ROWS      = 64;
    localparam int STACK_ENTRIES = 16384;

    localparam int COORD_W  = 6;
    localparam int DIM_W    = 7;
    localparam int CELLS    = MAX_COLS * MAX_ROWS;
    localparam int CELL_AW  = $clog2(CELLS);
    localparam int STACK_AW = $clog2(STACK_ENTRIES);
    localparam int CNT_W    = STACK_AW + 1;
    localparam int FROM_W   = 3;
    localparam int ENTRY_W  = 2 * COORD_W + FROM_W;
    localparam int CELL_W   = 5;

    localparam logic [3:0] WALL_N = 4'b1000;
    localparam logic [3:0] WALL_E = 4'b0100;
    localparam logic [3:0] WALL_S = 4'b0010;
    localparam logic [3:0] WALL_W = 4'b0001;

    typedef enum logic [1:0] {
        DIR_WEST  = 2'd0,
        DIR_EAST  = 2'd1,
        DIR_NORTH = 2'd2,
        DIR_SOUTH = 2'd3
    } dir_t;

    // direction from parent: 0 none, else 1 + direction it was pushed in
    typedef enum logic [FROM_W-1:0] {
        FROM_NONE  = 3'd0,
        FROM_WEST  = 3'd1,
        FROM_EAST  = 3'd2,
        FROM_NORTH = 3'd3,
        FROM_SOUTH = 3'd4
    } from_t;

    typedef enum logic {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } cfg_idx_t;

    typedef enum logic [0:0] {
        OP_CARVE = 1'b0,
        OP_READ  = 1'b1
    } op_t;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
        if (v == '0)
            return DIM_W'(1);
        return (v > maxv) ? maxv : v;
    endfunction

    function automatic logic [CELL_AW-1:0] cell_idx(input logic [DIM_W-1:0] x,
                                                    input logic [DIM_W-1:0] y);
        return CELL_AW'(y) * CELL_AW'(MAX_COLS) + CELL_AW'(x);
    endfunction

    // Lexicographic permutation of W,E,N,S; slot i in bits [2i+1:2i].
    function automatic logic [7:0] perm_order(input logic [4:0] code_in);
        logic [4:0] c;
        logic [2:0] r;
        logic [1:0] k [3];
        logic [1:0] pool [4];
        logic [7:0] ord;
        c = (code_in >= 5'd24) ? code_in - 5'd24 : code_in;
        if (c >= 5'd18) begin
            k[0] = 2'd3;
            r = 3'(c - 5'd18);
        end
        else if (c >= 5'd12) begin
            k[0] = 2'd2;
            r = 3'(c - 5'd12);
        end
        else if (c >= 5'd6) begin
            k[0] = 2'd1;
            r = 3'(c - 5'd6);
        end
        else begin
            k[0] = 2'd0;
            r = 3'(c);
        end
        k[1] = r[2:1];
        k[2] = {1'b0, r[0]};
        pool[0] = DIR_WEST;
        pool[1] = DIR_EAST;
        pool[2] = DIR_NORTH;
        pool[3] = DIR_SOUTH;
        ord = '0;
        for (int i = 0; i < 3; i++) begin
            ord[2*i +: 2] = pool[k[i]];
            for (int j = 0; j < 3; j++) begin
                if (j >= int'(k[i]))
                    pool[j] = pool[j+1];
            end
        end
        ord[7:6] = pool[0];
        return ord;
    endfunction

endpackage

### sv/dmc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

### sv/dfs_maze_carver.sv
// Randomized depth-first maze carver: cell RAM {visited, walls} and stack RAM.
// Depends on dmc_pkg and dmc_ram.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------------
//  in      | input     | in_valid / in_ready | operation, order_code, read_x, read_y
//  out     | output    | out_valid/out_ready | carved, finished, cell_x, cell_y, open_walls
//  cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// After reset a clearing pass zeroes all CELLS (4096) cell RAM words; in_ready is low.
// A read fetches the cell word. A carve pops entries past off-grid or visited ones until
// the stack is empty or a fresh cell turns up, marks it visited, opens the wall to its
// parent if linked, and pushes each unvisited in-grid neighbor while the stack has room.
// The cell RAM gives one read a cycle, so wall and visited accesses go one at a time.
// The next item is taken while a result waits; DONE holds until the output register frees.
module dfs_maze_carver
    import dmc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               operation,
    input  logic [4:0]         order_code,
    input  logic [COORD_W-1:0] read_x,
    input  logic [COORD_W-1:0] read_y,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               carved,
    output logic               finished,
    output logic [COORD_W-1:0] cell_x,
    output logic [COORD_W-1:0] cell_y,
    output logic [3:0]         open_walls,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [DIM_W-1:0]   cfg_data
);

    typedef enum logic [9:0] {
        ST_CLEAR = 10'b0000000001,
        ST_IDLE  = 10'b0000000010,
        ST_POP   = 10'b0000000100,
        ST_POP_W = 10'b0000001000,
        ST_CHK   = 10'b0000010000,
        ST_PAR   = 10'b0000100000,
        ST_NB    = 10'b0001000000,
        ST_NB_W  = 10'b0010000000,
        ST_RD_W  = 10'b0100000000,
        ST_DONE  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic [CELL_AW-1:0] clr_addr_reg, clr_addr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [DIM_W-1:0]   width_reg, height_reg;
    logic [1:0]         nb_i_reg, nb_i_next;
    logic               out_valid_reg, out_valid_next;

    // payload registers
    logic [7:0]         order_reg, order_next;
    logic [COORD_W-1:0] ent_x_reg, ent_x_next, ent_y_reg, ent_y_next;
    logic [FROM_W-1:0]  ent_from_reg, ent_from_next;
    logic [CELL_AW-1:0] idx_reg, idx_next, par_idx_reg, par_idx_next;
    logic [3:0]         theirs_reg, theirs_next;
    logic [COORD_W-1:0] nb_x_reg, nb_x_next, nb_y_reg, nb_y_next;
    logic [FROM_W-1:0]  nb_from_reg, nb_from_next;
    logic               rd_ok_reg, rd_ok_next;
    logic               res_carved_reg, res_carved_next;
    logic [COORD_W-1:0] res_x_reg, res_x_next, res_y_reg, res_y_next;
    logic [3:0]         res_walls_reg, res_walls_next;
    logic               carved_reg, carved_next, finished_reg, finished_next;
    logic [COORD_W-1:0] cell_x_reg, cell_x_next, cell_y_reg, cell_y_next;
    logic [3:0]         walls_reg, walls_next;

    logic               cell_we;
    logic [CELL_AW-1:0] cell_waddr, cell_raddr;
    logic [CELL_W-1:0]  cell_wdata, cell_rdata;
    logic               stk_we;
    logic [STACK_AW-1:0] stk_waddr, stk_raddr;
    logic [ENTRY_W-1:0] stk_wdata, stk_rdata;

    logic [DIM_W-1:0]   w_eff, h_eff;
    logic [DIM_W-1:0]   pop_x, pop_y, ex, ey, px, py, nx, ny;
    logic [3:0]         mine, theirs, cur_walls;
    logic               link, nb_ok;
    logic [1:0]         dir;

    dmc_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_cell_ram (
        .clk   (clk),
        .we    (cell_we),
        .waddr (cell_waddr),
        .wdata (cell_wdata),
        .raddr (cell_raddr),
        .rdata (cell_rdata)
    );

    dmc_ram #(.WIDTH(ENTRY_W), .DEPTH(STACK_ENTRIES)) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    assign w_eff = eff_dim(width_reg, DIM_W'(MAX_COLS));
    assign h_eff = eff_dim(height_reg, DIM_W'(MAX_ROWS));
    assign pop_x = DIM_W'(stk_rdata[COORD_W-1:0]);
    assign pop_y = DIM_W'(stk_rdata[2*COORD_W-1:COORD_W]);
    assign ex    = DIM_W'(ent_x_reg);
    assign ey    = DIM_W'(ent_y_reg);

    // parent cell and wall pair of the popped entry
    always_comb
    begin
        px = ex;
        py = ey;
        mine = '0;
        theirs = '0;
        unique case (ent_from_reg)
            FROM_WEST:
            begin
                px = ex + DIM_W'(1);
                mine = WALL_E;
                theirs = WALL_W;
            end
            FROM_EAST:
            begin
                px = ex - DIM_W'(1);
                mine = WALL_W;
                theirs = WALL_E;
            end
            FROM_NORTH:
            begin
                py = ey + DIM_W'(1);
                mine = WALL_S;
                theirs = WALL_N;
            end
            FROM_SOUTH:
            begin
                py = ey - DIM_W'(1);
                mine = WALL_N;
                theirs = WALL_S;
            end
            default: ;
        endcase
        link = (mine != '0) && (px < DIM_W'(MAX_COLS)) && (py < DIM_W'(MAX_ROWS));
        cur_walls = cell_rdata[3:0] | (link ? mine : 4'b0000);
    end

    // neighbor for the current push slot
    always_comb
    begin
        dir = order_reg[2*nb_i_reg +: 2];
        nx = ex;
        ny = ey;
        nb_ok = 1'b1;
        unique case (dir)
            DIR_WEST:
            begin
                nb_ok = (ex != '0);
                nx = ex - DIM_W'(1);
            end
            DIR_EAST:  nx = ex + DIM_W'(1);
            DIR_NORTH:
            begin
                nb_ok = (ey != '0);
                ny = ey - DIM_W'(1);
            end
            DIR_SOUTH: ny = ey + DIM_W'(1);
            default: ;
        endcase
        nb_ok = nb_ok && (nx < w_eff) && (ny < h_eff);
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        count_next      = count_reg;
        nb_i_next       = nb_i_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        order_next      = order_reg;
        ent_x_next      = ent_x_reg;
        ent_y_next      = ent_y_reg;
        ent_from_next   = ent_from_reg;
        idx_next        = idx_reg;
        par_idx_next    = par_idx_reg;
        theirs_next     = theirs_reg;
        nb_x_next       = nb_x_reg;
        nb_y_next       = nb_y_reg;
        nb_from_next    = nb_from_reg;
        rd_ok_next      = rd_ok_reg;
        res_carved_next = res_carved_reg;
        res_x_next      = res_x_reg;
        res_y_next      = res_y_reg;
        res_walls_next  = res_walls_reg;
        carved_next     = carved_reg;
        finished_next   = finished_reg;
        cell_x_next     = cell_x_reg;
        cell_y_next     = cell_y_reg;
        walls_next      = walls_reg;
        cell_we    = 1'b0;
        cell_waddr = idx_reg;
        cell_wdata = '0;
        cell_raddr = idx_reg;
        stk_we     = 1'b0;
        stk_waddr  = count_reg[STACK_AW-1:0];
        stk_wdata  = {nb_from_reg, nb_y_reg, nb_x_reg};
        stk_raddr  = count_reg[STACK_AW-1:0];
        in_ready   = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                cell_we    = 1'b1;
                cell_waddr = clr_addr_reg;
                cell_wdata = '0;
                // entry 0: start cell, no parent
                stk_we     = (clr_addr_reg == '0);
                stk_waddr  = '0;
                stk_wdata  = '0;
                clr_addr_next = clr_addr_reg + CELL_AW'(1);
                if (clr_addr_reg == CELL_AW'(CELLS - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid) begin
                    res_carved_next = 1'b0;
                    if (operation == OP_READ) begin
                        cell_raddr = cell_idx(DIM_W'(read_x), DIM_W'(read_y));
                        res_x_next = read_x;
                        res_y_next = read_y;
                        rd_ok_next = (DIM_W'(read_x) < DIM_W'(MAX_COLS))
                                  && (DIM_W'(read_y) < DIM_W'(MAX_ROWS));
                        state_next = ST_RD_W;
                    end
                    else begin
                        order_next     = perm_order(order_code);
                        res_x_next     = '0;
                        res_y_next     = '0;
                        res_walls_next = '0;
                        state_next     = ST_POP;
                    end
                end
            end
            ST_RD_W:
            begin
                res_walls_next = rd_ok_reg ? cell_rdata[3:0] : 4'b0000;
                state_next = ST_DONE;
            end
            ST_POP:
            begin
                if (count_reg == '0) begin
                    state_next = ST_DONE;
                end
                else begin
                    count_next = count_reg - CNT_W'(1);
                    stk_raddr  = count_next[STACK_AW-1:0];
                    state_next = ST_POP_W;
                end
            end
            ST_POP_W:
            begin
                ent_x_next    = stk_rdata[COORD_W-1:0];
                ent_y_next    = stk_rdata[2*COORD_W-1:COORD_W];
                ent_from_next = stk_rdata[ENTRY_W-1:2*COORD_W];
                if (pop_x < w_eff && pop_y < h_eff) begin
                    cell_raddr = cell_idx(pop_x, pop_y);
                    idx_next   = cell_raddr;
                    state_next = ST_CHK;
                end
                else begin
                    state_next = ST_POP;
                end
            end
            ST_CHK:
            begin
                if (cell_rdata[4]) begin
                    state_next = ST_POP;
                end
                else begin
                    cell_we         = 1'b1;
                    cell_waddr      = idx_reg;
                    cell_wdata      = {1'b1, cur_walls};
                    res_carved_next = 1'b1;
                    res_x_next      = ent_x_reg;
                    res_y_next      = ent_y_reg;
                    res_walls_next  = cur_walls;
                    nb_i_next       = '0;
                    if (link) begin
                        cell_raddr   = cell_idx(px, py);
                        par_idx_next = cell_raddr;
                        theirs_next  = theirs;
                        state_next   = ST_PAR;
                    end
                    else begin
                        state_next = ST_NB;
                    end
                end
            end
            ST_PAR:
            begin
                cell_we    = 1'b1;
                cell_waddr = par_idx_reg;
                cell_wdata = cell_rdata | {1'b0, theirs_reg};
                state_next = ST_NB;
            end
            ST_NB:
            begin
                if (nb_ok) begin
                    cell_raddr   = cell_idx(nx, ny);
                    nb_x_next    = nx[COORD_W-1:0];
                    nb_y_next    = ny[COORD_W-1:0];
                    nb_from_next = FROM_W'(dir) + FROM_W'(1);
                    state_next   = ST_NB_W;
                end
                else if (nb_i_reg == 2'd3) begin
                    state_next = ST_DONE;
                end
                else begin
                    nb_i_next = nb_i_reg + 2'd1;
                end
            end
            ST_NB_W:
            begin
                if (!cell_rdata[4] && count_reg < CNT_W'(STACK_ENTRIES)) begin
                    stk_we     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
                if (nb_i_reg == 2'd3) begin
                    state_next = ST_DONE;
                end
                else begin
                    nb_i_next  = nb_i_reg + 2'd1;
                    state_next = ST_NB;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready) begin
                    out_valid_next = 1'b1;
                    carved_next    = res_carved_reg;
                    finished_next  = (count_reg == '0);
                    cell_x_next    = res_x_reg;
                    cell_y_next    = res_y_reg;
                    walls_next     = res_walls_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            count_reg     <= CNT_W'(1);
            nb_i_reg      <= '0;
            out_valid_reg <= 1'b0;
            width_reg     <= DIM_W'(64);
            height_reg    <= DIM_W'(64);
        end
        else begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            count_reg     <= count_next;
            nb_i_reg      <= nb_i_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_WIDTH:  width_reg  <= cfg_data;
                    CFG_HEIGHT: height_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        order_reg      <= order_next;
        ent_x_reg      <= ent_x_next;
        ent_y_reg      <= ent_y_next;
        ent_from_reg   <= ent_from_next;
        idx_reg        <= idx_next;
        par_idx_reg    <= par_idx_next;
        theirs_reg     <= theirs_next;
        nb_x_reg       <= nb_x_next;
        nb_y_reg       <= nb_y_next;
        nb_from_reg    <= nb_from_next;
        rd_ok_reg      <= rd_ok_next;
        res_carved_reg <= res_carved_next;
        res_x_reg      <= res_x_next;
        res_y_reg      <= res_y_next;
        res_walls_reg  <= res_walls_next;
        carved_reg     <= carved_next;
        finished_reg   <= finished_next;
        cell_x_reg     <= cell_x_next;
        cell_y_reg     <= cell_y_next;
        walls_reg      <= walls_next;
    end

    assign cfg_ready  = 1'b1;
    assign out_valid  = out_valid_reg;
    assign carved     = carved_reg;
    assign finished   = finished_reg;
    assign cell_x     = cell_x_reg;
    assign cell_y     = cell_y_reg;
    assign open_walls = walls_reg;

endmodule

### sv/dmc_checker.sv
// Port-level checker for dfs_maze_carver, bound into every dfs_maze_carver instance.
// Depends on dmc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dmc_checker
    import dmc_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic               carved,
    input logic               finished,
    input logic [COORD_W-1:0] cell_x,
    input logic [COORD_W-1:0] cell_y,
    input logic [3:0]         open_walls
);

    logic       in_acc, out_acc;
    logic [1:0] pending_reg;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    // items taken but whose result is not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else if (in_acc && !out_acc)
            pending_reg <= pending_reg + 2'd1;
        else if (out_acc && !in_acc)
            pending_reg <= pending_reg - 2'd1;
    end

    `DMC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable({carved, finished, cell_x, cell_y, open_walls}),
        "result changed while stalled")
    `DMC_ASSERT_NEXT(a_one_at_a_time, in_acc, !in_ready,
        "item taken while previous still in work")
    `DMC_ASSERT_NOW(a_no_phantom, out_valid, pending_reg != 2'd0,
        "result without an item")
    `DMC_ASSERT_NOW(a_bounded, 1'b1, pending_reg != 2'd3,
        "more than two items in flight")

endmodule

bind dfs_maze_carver dmc_checker u_dmc_checker (.*);
